>>> rtl/two_stack_sliding_window_max_unit_assert.svh
// Assertion macros used by the sliding-window maximum RTL.
`ifndef TWO_STACK_SLIDING_WINDOW_MAX_UNIT_ASSERT_SVH
`define TWO_STACK_SLIDING_WINDOW_MAX_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Check a clocked property, masked while reset is asserted.
`define TSSWM_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Check that a condition never holds at a clock edge outside reset.
`define TSSWM_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);
`else
`define TSSWM_ASSERT(lbl, clk, rstn, prop, msg)
`define TSSWM_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

>>> rtl/tsswm_pkg.sv
// Shared types, constants and helper functions of the sliding-window maximum unit.
package tsswm_pkg;

	localparam int SAMPLE_W       = 32;
	localparam int LEN_W          = 5;
	localparam int MAX_WINDOW_DEF = 16;
	localparam logic [LEN_W-1:0] LEN_RESET = 5'd16;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// Signed maximum of two samples.
	function automatic sample_t smax(sample_t a, sample_t b);
		return (a >= b) ? a : b;
	endfunction

	// Clamp a programmed window length into 1 .. max_win.
	function automatic int eff_len(logic [LEN_W-1:0] len, int max_win);
		int v;
		v = int'(len);
		if (v < 1) begin
			v = 1;
		end
		if (v > max_win) begin
			v = max_win;
		end
		return v;
	endfunction

endpackage

>>> rtl/tsswm_if.sv
// Stream interfaces for the sample input and the window maximum output.
interface tsswm_sample_if;
	logic              valid;
	logic              ready;
	tsswm_pkg::sample_t sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface tsswm_max_if;
	logic              valid;
	logic              ready;
	tsswm_pkg::sample_t window_max;

	modport source (output valid, output window_max, input ready);
	modport sink   (input valid, input window_max, output ready);
endinterface

>>> rtl/tsswm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
module tsswm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write on enable, register the read word every cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/two_stack_sliding_window_max_unit.sv
// Top level of the two-stack sliding-window maximum unit.
//
// Channels: samples (sink) takes one signed 32-bit word per handshake; results
// (source) gives one signed 32-bit window maximum per handshake. cfg_wr_en with
// cfg_wr_data programs the window length (0 acts as 1, values above MAX_WINDOW
// act as MAX_WINDOW) and restarts the stream; write it only while idle.
// The first window_len words give no result. Each later word gives the maximum
// of itself and the window_len words before it.
// Sequence: a filling word is accepted and written to the front RAM. A streaming
// word is accepted while the suffix-max RAM is read, then merged into the output register.
// Every window_len-th streaming word first walks the front RAM from its top to
// its bottom to rebuild the suffix maxima, one entry per cycle; this walk
// lowers the average word rate.
// Reset: window length returns to 16 (clamped to MAX_WINDOW), stacks empty, no
// clearing pass; RAM contents are only read after being written.
// Stall: a finished result waits in the output register while the next word is
// accepted; if a second result is ready before the first is taken, it is held
// and the input stays not ready until the output register frees.
`include "two_stack_sliding_window_max_unit_assert.svh"

module two_stack_sliding_window_max_unit #(
	parameter int MAX_WINDOW = tsswm_pkg::MAX_WINDOW_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [tsswm_pkg::LEN_W-1:0]    cfg_wr_data,
	tsswm_sample_if.sink                   samples,
	tsswm_max_if.source                    results
);

	localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CW = $clog2(MAX_WINDOW + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SUF  = 2'd1;
	localparam logic [1:0] ST_FLIP = 2'd2;
	localparam logic [1:0] ST_RES  = 2'd3;

	logic [1:0]          state_q;
	logic [CW-1:0]       eff_q;
	logic [CW-1:0]       top_q;
	logic                filled_q;
	logic [AW-1:0]       idx_q;
	logic                out_valid_q;
	tsswm_pkg::sample_t  sample_q;
	tsswm_pkg::sample_t  prefix_q;
	tsswm_pkg::sample_t  acc_q;
	tsswm_pkg::sample_t  res_q;
	tsswm_pkg::sample_t  out_data_q;

	logic                in_acc;
	logic                out_free;
	logic                out_load;
	logic [AW-1:0]       w_last;
	logic [CW-1:0]       top_inc;
	tsswm_pkg::sample_t  new_prefix;
	tsswm_pkg::sample_t  acc_new;
	tsswm_pkg::sample_t  res_next;
	logic                res_done;

	logic                front_we;
	logic [AW-1:0]       front_waddr;
	tsswm_pkg::sample_t  front_wdata;
	logic [AW-1:0]       front_raddr;
	tsswm_pkg::sample_t  front_rdata;
	logic                suf_we;
	logic [AW-1:0]       suf_waddr;
	logic [AW-1:0]       suf_raddr;
	tsswm_pkg::sample_t  suf_rdata;

	// Front stack samples, kept for the flip walk.
	tsswm_ram #(
		.WIDTH (tsswm_pkg::SAMPLE_W),
		.DEPTH (MAX_WINDOW)
	) u_front_ram (
		.clk   (clk),
		.we    (front_we),
		.waddr (front_waddr),
		.wdata (front_wdata),
		.raddr (front_raddr),
		.rdata (front_rdata)
	);

	// Suffix maxima of the flipped stack, addressed by front slot.
	tsswm_ram #(
		.WIDTH (tsswm_pkg::SAMPLE_W),
		.DEPTH (MAX_WINDOW)
	) u_suf_ram (
		.clk   (clk),
		.we    (suf_we),
		.waddr (suf_waddr),
		.wdata (acc_new),
		.raddr (suf_raddr),
		.rdata (suf_rdata)
	);

	// Handshake and datapath helpers.
	assign samples.ready      = (state_q == ST_IDLE);
	assign in_acc             = samples.valid & samples.ready;
	assign out_free           = !out_valid_q || results.ready;
	assign out_load           = !cfg_wr_en && out_free && (res_done || (state_q == ST_RES));
	assign results.valid      = out_valid_q;
	assign results.window_max = out_data_q;
	assign w_last             = AW'(eff_q - CW'(1));
	assign top_inc            = CW'(top_q + CW'(1));
	assign new_prefix         = tsswm_pkg::smax(sample_q, prefix_q);
	assign acc_new            = (idx_q == w_last) ? front_rdata
	                                              : tsswm_pkg::smax(front_rdata, acc_q);

	// Result merge and completion of the current word.
	always_comb begin
		res_next = tsswm_pkg::smax(new_prefix, suf_rdata);
		res_done = 1'b0;
		if (state_q == ST_SUF) begin
			res_done = 1'b1;
		end else if (state_q == ST_FLIP) begin
			res_next = tsswm_pkg::smax(sample_q, acc_new);
			res_done = (idx_q == '0);
		end
	end

	// Steer the RAM ports.
	always_comb begin
		front_we    = 1'b0;
		front_waddr = top_q[AW-1:0];
		front_wdata = sample_q;
		front_raddr = (state_q == ST_IDLE) ? w_last : AW'(idx_q - AW'(1));
		suf_we      = 1'b0;
		suf_waddr   = idx_q;
		suf_raddr   = top_q[AW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && !filled_q) begin
					front_we    = 1'b1;
					front_wdata = samples.sample;
				end
			end
			ST_SUF: begin
				front_we = 1'b1;
			end
			ST_FLIP: begin
				suf_we = 1'b1;
				if (idx_q == '0) begin
					front_we    = 1'b1;
					front_waddr = '0;
				end
			end
			ST_RES: begin
			end
			default: begin
			end
		endcase
	end

	// Sequencer: fill, stream, flip walk, output hold.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			eff_q       <= CW'(tsswm_pkg::eff_len(tsswm_pkg::LEN_RESET, MAX_WINDOW));
			top_q       <= '0;
			filled_q    <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Load a finished word into the output register, drop it once taken.
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				eff_q    <= CW'(tsswm_pkg::eff_len(cfg_wr_data, MAX_WINDOW));
				top_q    <= '0;
				filled_q <= 1'b0;
			end else begin
				unique case (state_q)
					ST_IDLE: begin
						if (in_acc) begin
							if (!filled_q) begin
								top_q <= top_inc;
								if (top_inc >= eff_q) begin
									filled_q <= 1'b1;
								end
							end else if (top_q >= eff_q) begin
								idx_q   <= w_last;
								state_q <= ST_FLIP;
							end else begin
								state_q <= ST_SUF;
							end
						end
					end
					ST_SUF: begin
						top_q <= top_inc;
					end
					ST_FLIP: begin
						if (idx_q != '0) begin
							idx_q <= AW'(idx_q - AW'(1));
						end else begin
							top_q <= CW'(1);
						end
					end
					ST_RES: begin
						if (out_free) begin
							state_q <= ST_IDLE;
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
				if (res_done) begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_RES;
					end
				end
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_q <= samples.sample;
		end
		if (state_q == ST_SUF) begin
			prefix_q <= new_prefix;
		end
		if (state_q == ST_FLIP) begin
			acc_q <= acc_new;
			if (idx_q == '0) begin
				prefix_q <= sample_q;
			end
		end
		if (res_done) begin
			res_q <= res_next;
			if (out_free) begin
				out_data_q <= res_next;
			end
		end
		if (state_q == ST_RES && out_free) begin
			out_data_q <= res_q;
		end
	end

	// Checks.
	`TSSWM_ASSERT(a_top_in_window, clk, arst_n, top_q <= eff_q, "front stack past window")
	`TSSWM_ASSERT(a_flip_ends_at_one, clk, arst_n,
		(state_q == ST_FLIP && idx_q == '0 && !cfg_wr_en) |=> (top_q == CW'(1)),
		"flip walk did not restart front stack")
	`TSSWM_NEVER(a_stream_top_zero, clk, arst_n,
		in_acc && filled_q && (top_q < eff_q) && (top_q == '0),
		"streaming word with empty front stack")
	`TSSWM_ASSERT(a_result_needs_fill, clk, arst_n,
		$rose(results.valid) |-> $past(filled_q), "result before window filled")

endmodule

>>> tb/two_stack_sliding_window_max_unit_tb.sv
// Self-checking testbench for the two-stack sliding-window maximum unit.
module two_stack_sliding_window_max_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef tsswm_pkg::sample_t sample_t;

	localparam int LEN_W         = tsswm_pkg::LEN_W;
	localparam int MAXW          = tsswm_pkg::MAX_WINDOW_DEF;
	localparam int SETTLE_CYCLES = 2 * MAXW + 8;
	localparam int PARK_CYCLES   = 400;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int PHASES        = 12;
	localparam int WORDS_PER_PHASE = 150;
	localparam int PLAN_LEN      = 26;

	typedef enum logic [0:0] {ROW_WORD, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		logic [31:0] data;
		logic typed;
		sample_t want;
	} stim_row_t;

	// Directed plan: reset window of 16, then a window of 1 (written as 0), then 31 (clamps to 16)
	localparam stim_row_t PLAN [PLAN_LEN] = '{
		'{ROW_WORD, 32'h7fffffff, 1'b0, '0},
		'{ROW_WORD, 32'h80000000, 1'b0, '0},
		'{ROW_WORD, 32'h00000000, 1'b0, '0},
		'{ROW_WORD, 32'hffffffff, 1'b0, '0},
		'{ROW_WORD, 32'h00000001, 1'b0, '0},
		'{ROW_WORD, 32'h55555555, 1'b0, '0},
		'{ROW_WORD, 32'haaaaaaaa, 1'b0, '0},
		'{ROW_WORD, 32'hfffffffe, 1'b0, '0},
		'{ROW_WORD, 32'h7ffffffe, 1'b0, '0},
		'{ROW_WORD, 32'h80000001, 1'b0, '0},
		'{ROW_WORD, 32'h00000003, 1'b0, '0},
		'{ROW_WORD, 32'hfffffffd, 1'b0, '0},
		'{ROW_WORD, 32'h40000000, 1'b0, '0},
		'{ROW_WORD, 32'hc0000000, 1'b0, '0},
		'{ROW_WORD, 32'h00000100, 1'b0, '0},
		'{ROW_WORD, 32'hffffff00, 1'b0, '0},
		'{ROW_WORD, 32'h80000000, 1'b1, 32'h7fffffff},
		'{ROW_WORD, 32'h80000000, 1'b0, '0},
		'{ROW_CFG,  32'd0,        1'b0, '0},
		'{ROW_WORD, 32'h80000000, 1'b0, '0},
		'{ROW_WORD, 32'h80000000, 1'b1, 32'h80000000},
		'{ROW_WORD, 32'h7fffffff, 1'b1, 32'h7fffffff},
		'{ROW_WORD, 32'h80000000, 1'b1, 32'h7fffffff},
		'{ROW_WORD, 32'h00000000, 1'b1, 32'h00000000},
		'{ROW_WORD, 32'hffffffff, 1'b1, 32'h00000000},
		'{ROW_CFG,  32'd31,       1'b0, '0}
	};

	localparam logic [LEN_W-1:0] PHASE_LEN [PHASES] = '{
		5'd31, 5'd1, 5'd2, 5'd16, 5'd0, 5'd5, 5'd17, 5'd8, 5'd3, 5'd12, 5'd15, 5'd7
	};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [LEN_W-1:0] cfg_wr_data;

	tsswm_sample_if smp_if();
	tsswm_max_if    res_if();

	two_stack_sliding_window_max_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.samples     (smp_if),
		.results     (res_if)
	);

	always #4 clk = ~clk;

	// Window-max predictor state
	sample_t fr_val [MAXW];
	sample_t fr_max [MAXW];
	sample_t bk_val [MAXW];
	sample_t bk_max [MAXW];
	int unsigned stack_depth;
	bit window_full;
	logic [LEN_W-1:0] len_reg;

	sample_t pending_max [$];
	int err_count = 0;
	int cycle_count = 0;

	// Flow control knobs shared between stimulus and the result side
	bit src_burst = 1'b0;
	bit sink_steady = 1'b0;
	bit park_start = 1'b0;
	bit park_taken = 1'b0;
	int stall_left = 0;

	function automatic sample_t larger(sample_t a, sample_t b);
		return (a >= b) ? a : b;
	endfunction

	function automatic int span_len();
		int w;
		w = int'(len_reg);
		if (w < 1) begin
			w = 1;
		end
		if (w > MAXW) begin
			w = MAXW;
		end
		return w;
	endfunction

	// Advance the two stacks by one word; return 1 when a window max comes out
	function automatic bit window_max_step(input sample_t s, output sample_t m);
		int w;
		int t;
		w = span_len();
		m = '0;
		if (!window_full && stack_depth < w) begin
			fr_val[stack_depth] = s;
			fr_max[stack_depth] = (stack_depth == 0) ? s : larger(s, fr_max[stack_depth-1]);
			stack_depth++;
			if (stack_depth >= w) begin
				window_full = 1'b1;
			end
			return 1'b0;
		end
		window_full = 1'b1;
		// Flip: reverse front into back, rebuild the prefix maxima
		if (stack_depth >= w) begin
			for (int i = 0; i < w; i++) begin
				bk_val[w-1-i] = fr_val[i];
			end
			bk_max[0] = bk_val[0];
			for (int i = 1; i < w; i++) begin
				bk_max[i] = larger(bk_max[i-1], bk_val[i]);
			end
			stack_depth = 0;
		end
		t = stack_depth;
		fr_val[t] = s;
		fr_max[t] = (t == 0) ? s : larger(s, fr_max[t-1]);
		m = larger(fr_max[t], bk_max[w-1-t]);
		stack_depth = t + 1;
		return 1'b1;
	endfunction

	// Mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end else if (r < 98) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 40);
	endfunction

	function automatic void report(string what, sample_t want, sample_t got);
		err_count++;
		if (err_count <= 10) begin
			$display("%0t: %s: expected %0d (%h) got %0d (%h)", $realtime, what,
				want, want, got, got);
		end
	endfunction

	// Offer one word, hold it until taken, then predict its result
	task automatic send_word(input sample_t s, input logic typed, input sample_t want);
		int gap;
		sample_t m;
		gap = src_burst ? 0 : pick_gap();
		if (gap > 0) begin
			smp_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		smp_if.valid  <= 1'b1;
		smp_if.sample <= s;
		do @(posedge clk); while (!(smp_if.valid && smp_if.ready));
		if (window_max_step(s, m)) begin
			pending_max.push_back(typed ? want : m);
		end
	endtask

	// Drop valid, wait out every expected word, then let the block go quiet
	task automatic drain_and_settle();
		smp_if.valid <= 1'b0;
		while (pending_max.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_len(input logic [LEN_W-1:0] v);
		drain_and_settle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		len_reg     = v;
		stack_depth = 0;
		window_full = 1'b0;
	endtask

	// Result side: random ready with an optional long park
	always @(posedge clk) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else if (park_start && !park_taken) begin
			park_taken = 1'b1;
			stall_left = PARK_CYCLES - 1;
			res_if.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			res_if.ready <= 1'b0;
		end else if (sink_steady) begin
			res_if.ready <= 1'b1;
		end else begin
			stall_left = pick_gap();
			if (stall_left == 0) begin
				res_if.ready <= 1'b1;
			end else begin
				stall_left--;
				res_if.ready <= 1'b0;
			end
		end
	end

	// Compare each taken word with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready) begin
			if (pending_max.size() == 0) begin
				report("unexpected window max", '0, res_if.window_max);
			end else if (res_if.window_max !== pending_max[0]) begin
				report("window max mismatch", pending_max[0], res_if.window_max);
				void'(pending_max.pop_front());
			end else begin
				void'(pending_max.pop_front());
			end
		end
	end

	// Cycle guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL two_stack_sliding_window_max_unit");
			$finish;
		end
	end

	initial begin
		logic [LEN_W-1:0] len;
		sample_t s;
		int r;
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		smp_if.valid  = 1'b0;
		smp_if.sample = '0;
		len_reg       = tsswm_pkg::LEN_RESET;
		stack_depth   = 0;
		window_full   = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed plan
		for (int k = 0; k < PLAN_LEN; k++) begin
			if (PLAN[k].kind == ROW_CFG) begin
				write_len(PLAN[k].data[LEN_W-1:0]);
			end else begin
				send_word(PLAN[k].data, PLAN[k].typed, PLAN[k].want);
			end
		end

		// Random phases, each under its own window length and flow mode
		for (int ph = 0; ph < PHASES; ph++) begin
			len = (ph == PHASES - 1) ? LEN_W'($urandom_range(0, 31)) : PHASE_LEN[ph];
			write_len(len);
			src_burst   = (ph % 4 == 1) || (ph % 4 == 3);
			sink_steady = (ph % 4 == 2) || (ph % 4 == 3);
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				// Park the result side while words keep coming
				if (ph == 3 && n == 40) begin
					park_start = 1'b1;
				end
				// Hold the input until every expected word is out
				if (ph == 5 && n == 75) begin
					smp_if.valid <= 1'b0;
					do @(posedge clk); while (pending_max.size() != 0);
				end
				r = $urandom_range(0, 9);
				case (r)
					0: s = 32'sh80000000;
					1: s = 32'sh7fffffff;
					2, 3, 4: s = sample_t'($urandom_range(0, 31)) - 16;
					default: s = sample_t'($urandom);
				endcase
				send_word(s, 1'b0, '0);
			end
		end

		src_burst = 1'b0;
		sink_steady = 1'b0;
		drain_and_settle();
		if (err_count == 0) begin
			$display("PASS two_stack_sliding_window_max_unit");
		end else begin
			$display("FAIL two_stack_sliding_window_max_unit");
		end
		$finish;
	end

endmodule
